// ===== rtl/iyfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package iyfd_pkg;

	// Operation codes carried by the mode field of an input word.
	typedef enum logic [1:0] {
		MODE_BYTE   = 2'd0,
		MODE_ZERO   = 2'd1,
		MODE_TARGET = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Frame layout.
	localparam int SUM_FIRST  = 2;
	localparam int SUM_END    = 15;
	localparam int YAW_LO_POS = 3;
	localparam int YAW_HI_POS = 4;

	// Angles in centidegrees.
	localparam int YAW_BIAS  = 18000;
	localparam int HALF_TURN = 18000;
	localparam int FULL_TURN = 36000;

	// floor(2^32 / 36000): the quotient estimate is exact or one low.
	localparam logic [16:0] TURN_RECIP = 17'd119304;
	localparam int RECIP_SHIFT = 32;

	// One decoded word, passed from the front end to the back end.
	typedef struct packed {
		mode_t              mode;
		logic               frame_done;
		logic               checksum_ok;
		logic signed [16:0] yaw_new;
		logic signed [23:0] add;
	} qent_t;

endpackage

`default_nettype wire

// ===== rtl/iyfd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface iyfd_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [7:0]         rx_byte;
	logic               frame_start;
	logic signed [23:0] degrees_to_add;

	modport source (output valid, mode, rx_byte, frame_start, degrees_to_add, input ready);
	modport sink (input valid, mode, rx_byte, frame_start, degrees_to_add, output ready);
endinterface

`default_nettype wire

// ===== rtl/iyfd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface iyfd_out_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] heading;
	logic signed [17:0] target_heading;
	logic               frame_done;
	logic               checksum_ok;

	modport source (output valid, heading, target_heading, frame_done, checksum_ok,
		input ready);
	modport sink (input valid, heading, target_heading, frame_done, checksum_ok,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/iyfd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iyfd_front import iyfd_pkg::*; #(
	parameter int FRAME_LEN = 19
) (
	input  wire logic clk,
	input  wire logic arst_n,
	iyfd_in_if.sink   items,
	input  wire logic full,
	output logic      push,
	output qent_t     entry
);

	localparam int CntW = $clog2(FRAME_LEN);

	logic [CntW-1:0] count_q;
	logic [7:0]      sum_q;
	logic [7:0]      lo_q;
	logic [7:0]      hi_q;

	logic [CntW-1:0] pos;
	logic [7:0]      sum_base;
	logic [7:0]      sum_n;
	logic            last;
	logic            is_byte;

	// Accept a word whenever the queue has room.
	assign items.ready = !full;
	assign push = items.valid && !full;

	// Byte position, running checksum and end of frame for this word.
	always_comb begin
		is_byte  = (mode_t'(items.mode) == MODE_BYTE);
		pos      = items.frame_start ? '0 : count_q;
		sum_base = (pos == '0) ? 8'd0 : sum_q;
		if (pos >= CntW'(SUM_FIRST) && pos < CntW'(SUM_END)) begin
			sum_n = sum_base + items.rx_byte;
		end else begin
			sum_n = sum_base;
		end
		last = (pos >= CntW'(FRAME_LEN - 1));
	end

	// Classified word for the back end.
	always_comb begin
		entry.mode        = mode_t'(items.mode);
		entry.frame_done  = is_byte && last;
		entry.checksum_ok = is_byte && last && (sum_n == items.rx_byte);
		entry.yaw_new     = {hi_q[7], hi_q, lo_q} - 17'(YAW_BIAS);
		entry.add         = items.degrees_to_add;
	end

	// Frame parser state moves only on received bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
		end else if (push && is_byte) begin
			sum_q <= sum_n;
			if (pos == CntW'(YAW_LO_POS)) begin
				lo_q <= items.rx_byte;
			end
			if (pos == CntW'(YAW_HI_POS)) begin
				hi_q <= items.rx_byte;
			end
			count_q <= last ? '0 : pos + CntW'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/iyfd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iyfd_queue import iyfd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t push_data,
	input  wire logic  pop,
	output logic       full,
	output logic       not_empty,
	output qent_t      pop_data
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	qent_t           mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CntW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/iyfd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iyfd_back import iyfd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire qent_t q_data,
	output logic       pop,
	iyfd_out_if.source results
);

	// Pipeline valids and payload.
	logic        vld_s1, vld_s2, vld_s3;
	qent_t       ent_s1, ent_s2, ent_s3;
	logic [23:0] mag_s1;
	logic [7:0]  quo_s1;
	logic        neg_s1, neg_s2;
	logic [16:0] rem_s2;
	logic signed [16:0] red_s3;

	// Architectural state.
	logic signed [16:0] yaw_q;
	logic signed [16:0] off_q;
	logic signed [16:0] head_q;

	// Output register.
	logic               out_vld_q;
	logic signed [16:0] out_head_q;
	logic signed [17:0] out_tgt_q;
	logic               out_done_q;
	logic               out_ok_q;

	logic advance;

	// The whole back end moves when the output register can take a word.
	assign advance = !out_vld_q || results.ready;
	assign pop     = advance && q_valid;

	// Stage 1: magnitude of the turn and a quotient estimate by reciprocal.
	logic [24:0] add_ext;
	logic [23:0] mag;
	logic [40:0] recip_prod;

	always_comb begin
		add_ext    = {q_data.add[23], q_data.add};
		mag        = q_data.add[23] ? 24'(-add_ext) : q_data.add[23:0];
		recip_prod = 41'(mag) * 41'(TURN_RECIP);
	end

	// Stage 2: remainder before its single correction.
	logic [23:0] quo_mul;
	logic [23:0] rem_raw;

	always_comb begin
		quo_mul = 24'(quo_s1) * 24'(FULL_TURN);
		rem_raw = mag_s1 - quo_mul;
	end

	// Stage 3: corrected remainder with the sign of the turn.
	logic [16:0] rem_fix;

	always_comb begin
		if (rem_s2 >= 17'(FULL_TURN)) begin
			rem_fix = rem_s2 - 17'(FULL_TURN);
		end else begin
			rem_fix = rem_s2;
		end
	end

	// Final step: apply the operation to the heading state.
	logic signed [16:0] sub_a, sub_b;
	logic signed [17:0] sub_diff;
	logic signed [16:0] sub_sat;
	logic signed [17:0] tgt_sum;
	logic signed [17:0] tgt_wrap;
	logic signed [16:0] head_n;
	logic signed [16:0] yaw_n;
	logic signed [16:0] off_n;
	logic signed [17:0] tgt_n;

	always_comb begin
		if (ent_s3.mode == MODE_BYTE) begin
			sub_a = ent_s3.yaw_new;
			sub_b = off_q;
		end else begin
			sub_a = yaw_q;
			sub_b = head_q;
		end
		sub_diff = {sub_a[16], sub_a} - {sub_b[16], sub_b};
		if (sub_diff > 18'sd65535) begin
			sub_sat = 17'h0FFFF;
		end else if (sub_diff < -18'sd65536) begin
			sub_sat = 17'h10000;
		end else begin
			sub_sat = sub_diff[16:0];
		end

		tgt_sum = {head_q[16], head_q} + {red_s3[16], red_s3};
		if (tgt_sum > 18'(HALF_TURN)) begin
			tgt_wrap = tgt_sum - 18'(FULL_TURN);
		end else if (tgt_sum < -18'(HALF_TURN)) begin
			tgt_wrap = tgt_sum + 18'(FULL_TURN);
		end else begin
			tgt_wrap = tgt_sum;
		end

		head_n = head_q;
		yaw_n  = yaw_q;
		off_n  = off_q;
		tgt_n  = '0;
		// Only a live word is decoded; a bubble leaves everything as it is.
		if (vld_s3) begin
			unique case (ent_s3.mode)
				MODE_BYTE: begin
					if (ent_s3.checksum_ok) begin
						yaw_n  = ent_s3.yaw_new;
						head_n = sub_sat;
					end
				end
				MODE_ZERO: begin
					off_n  = head_q;
					head_n = sub_sat;
				end
				MODE_TARGET: begin
					tgt_n = tgt_wrap;
				end
				MODE_NONE: begin
					head_n = head_q;
				end
			endcase
		end
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
			yaw_q     <= '0;
			off_q     <= '0;
			head_q    <= '0;
		end else if (advance) begin
			vld_s1    <= q_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			out_vld_q <= vld_s3;
			if (vld_s3) begin
				yaw_q  <= yaw_n;
				off_q  <= off_n;
				head_q <= head_n;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (advance) begin
			ent_s1     <= q_data;
			mag_s1     <= mag;
			quo_s1     <= recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
			neg_s1     <= q_data.add[23];
			ent_s2     <= ent_s1;
			rem_s2     <= rem_raw[16:0];
			neg_s2     <= neg_s1;
			ent_s3     <= ent_s2;
			red_s3     <= neg_s2 ? -$signed(rem_fix) : $signed(rem_fix);
			out_head_q <= head_n;
			out_tgt_q  <= tgt_n;
			out_done_q <= ent_s3.frame_done;
			out_ok_q   <= ent_s3.checksum_ok;
		end
	end

	assign results.valid          = out_vld_q;
	assign results.heading        = out_head_q;
	assign results.target_heading = out_tgt_q;
	assign results.frame_done     = out_done_q;
	assign results.checksum_ok    = out_ok_q;

endmodule

`default_nettype wire

// ===== rtl/imu_yaw_frame_decoder_unit.sv =====
// Channel   Role    Word contents
// items     sink    mode, rx_byte, frame_start, degrees_to_add
// results   source  heading, target_heading, frame_done, checksum_ok
//
// One word is accepted per cycle while the queue has room, and one result leaves per cycle while the output is taken.
// Each result passes through the queue, the three-stage modulo-36000 reduction
// of the turn and the output register.
// A four-entry queue lets the input keep going while the output is stalled.
// Reset clears the frame count, checksum, yaw, offset and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module imu_yaw_frame_decoder_unit import iyfd_pkg::*; #(
	parameter int FRAME_LEN   = 19,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	iyfd_in_if.sink    items,
	iyfd_out_if.source results
);

	logic  push;
	logic  full;
	logic  not_empty;
	logic  pop;
	qent_t push_data;
	qent_t pop_data;

	// Front end: frame parsing and classification.
	iyfd_front #(
		.FRAME_LEN(FRAME_LEN)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.items (items),
		.full  (full),
		.push  (push),
		.entry (push_data)
	);

	// Decoupling queue.
	iyfd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (full),
		.not_empty(not_empty),
		.pop_data (pop_data)
	);

	// Back end: turn reduction and heading state.
	iyfd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(not_empty),
		.q_data (pop_data),
		.pop    (pop),
		.results(results)
	);

endmodule

`default_nettype wire

// ===== rtl/iyfd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iyfd_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               res_valid,
	input wire logic               res_ready,
	input wire logic signed [17:0] res_target,
	input wire logic               res_done,
	input wire logic               res_ok
);

	// A passed checksum only comes with a completed frame.
	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ok |-> res_done)
		else $error("checksum_ok without frame_done");

	// A target query never completes a frame.
	a_target_not_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_target != 18'sd0) |-> !res_done)
		else $error("target heading on a frame word");

	// A saturated heading plus a reduced turn, wrapped once, stays within the
	// span of the heading itself.
	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_target <= 18'sd65535) && (res_target >= -18'sd65535))
		else $error("target heading out of range");

	// A stalled result is held.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_target))
		else $error("result dropped while stalled");

endmodule

bind imu_yaw_frame_decoder_unit iyfd_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_target(results.target_heading),
	.res_done  (results.frame_done),
	.res_ok    (results.checksum_ok)
);

`default_nettype wire
